>>> rtl/urng_pkg.sv
// ----------------------------------------------------------------------------
// urng_pkg: shared types and constants for the ultrasonic ranger alarm
// Phase codes, register indexes, configuration and result records.
// ----------------------------------------------------------------------------
package urng_pkg;

  // Field widths
  localparam int TPU_W  = 8;
  localparam int CM_W   = 9;
  localparam int US_W   = 20;
  localparam int ADDR_W = 3;

  // Trigger timing in microseconds
  localparam int PRE_LOW_US   = 2;
  localparam int TRIG_HIGH_US = 10;

  // Distance = micro_count * DIST_MUL / DIST_DIV, tracked incrementally
  localparam int DIST_MUL = 17;
  localparam int DIST_DIV = 1000;
  localparam int REM_W    = 10;
  localparam int DACC_W   = CM_W + 1;
  localparam int DIST_SAT = 1 << CM_W;

  // Register reset values
  localparam logic [TPU_W-1:0] RST_TICKS_PER_US = 8'd50;
  localparam logic [CM_W-1:0]  RST_MAX_RANGE_CM = 9'd400;
  localparam logic [CM_W-1:0]  RST_FAR_CM       = 9'd40;
  localparam logic [CM_W-1:0]  RST_MID_CM       = 9'd25;
  localparam logic [CM_W-1:0]  RST_NEAR_CM      = 9'd10;
  localparam logic [US_W-1:0]  RST_GUARD_US     = 20'd60000;
  localparam logic [US_W-1:0]  RST_BEEP_US      = 20'd100000;
  localparam logic [US_W-1:0]  RST_GAP_US       = 20'd300000;

  typedef enum logic [2:0] {
    PH_LOW   = 3'd0,
    PH_TRIG  = 3'd1,
    PH_WAIT  = 3'd2,
    PH_MEAS  = 3'd3,
    PH_GUARD = 3'd4,
    PH_BEEP  = 3'd5,
    PH_GAP   = 3'd6
  } phase_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_TICKS_PER_US = 3'd0,
    REG_MAX_RANGE_CM = 3'd1,
    REG_FAR_CM       = 3'd2,
    REG_MID_CM       = 3'd3,
    REG_NEAR_CM      = 3'd4,
    REG_GUARD_US     = 3'd5,
    REG_BEEP_US      = 3'd6,
    REG_GAP_US       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [TPU_W-1:0] ticks_per_us;
    logic [CM_W-1:0]  max_range_cm;
    logic [CM_W-1:0]  far_cm;
    logic [CM_W-1:0]  mid_cm;
    logic [CM_W-1:0]  near_cm;
    logic [US_W-1:0]  guard_us;
    logic [US_W-1:0]  beep_us;
    logic [US_W-1:0]  gap_us;
  } cfg_t;

  typedef struct packed {
    logic            trigger_out;
    logic            alarm_on;
    logic [CM_W-1:0] distance_cm;
    logic            distance_update;
    logic            out_of_range;
  } res_t;

endpackage

>>> rtl/ultrasonic_ranger_alarm.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranger_alarm: ultrasonic echo ranging controller with alarm
// Each accepted item is one sampled tick of the echo pin; each tick gives
// one result with trigger drive, alarm drive and the stored distance.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | push / full        | in_echo_level
//   result   | empty / pop        | out_trigger_out, out_alarm_on,
//            |                    | out_distance_cm, out_distance_update,
//            |                    | out_out_of_range
//   config   | cfg_we             | cfg_addr, cfg_wdata
//
// One item per cycle sustained while the reader keeps up; a tick is stepped out
// of the tick queue and its result is registered in the result queue to be read.
// Two-entry queues sit on both sides of the sequencer, so a stalled reader
// backs up into full only after both queues fill.
// Synchronous active-low reset restores register defaults and the
// pre-trigger low phase; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ultrasonic_ranger_alarm
  import urng_pkg::*;
#(
  parameter int COUNT_BITS = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input channel
  input  logic              push,
  output logic              full,
  input  logic              in_echo_level,
  // Result channel
  output logic              empty,
  input  logic              pop,
  output logic              out_trigger_out,
  output logic              out_alarm_on,
  output logic [CM_W-1:0]   out_distance_cm,
  output logic              out_distance_update,
  output logic              out_out_of_range,
  // Configuration
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [US_W-1:0]   cfg_wdata
);

  localparam int RW = $bits(res_t);

  cfg_t    cfg_r;
  logic    tick_empty;
  logic    tick_echo;
  logic    res_full;
  logic    step;
  res_t    res;
  res_t    res_q;
  logic [RW-1:0] res_q_bits;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ticks_per_us <= RST_TICKS_PER_US;
      cfg_r.max_range_cm <= RST_MAX_RANGE_CM;
      cfg_r.far_cm       <= RST_FAR_CM;
      cfg_r.mid_cm       <= RST_MID_CM;
      cfg_r.near_cm      <= RST_NEAR_CM;
      cfg_r.guard_us     <= RST_GUARD_US;
      cfg_r.beep_us      <= RST_BEEP_US;
      cfg_r.gap_us       <= RST_GAP_US;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_TICKS_PER_US: cfg_r.ticks_per_us <= cfg_wdata[TPU_W-1:0];
        REG_MAX_RANGE_CM: cfg_r.max_range_cm <= cfg_wdata[CM_W-1:0];
        REG_FAR_CM:       cfg_r.far_cm       <= cfg_wdata[CM_W-1:0];
        REG_MID_CM:       cfg_r.mid_cm       <= cfg_wdata[CM_W-1:0];
        REG_NEAR_CM:      cfg_r.near_cm      <= cfg_wdata[CM_W-1:0];
        REG_GUARD_US:     cfg_r.guard_us     <= cfg_wdata;
        REG_BEEP_US:      cfg_r.beep_us      <= cfg_wdata;
        REG_GAP_US:       cfg_r.gap_us       <= cfg_wdata;
      endcase
    end
  end

  // Front: queue incoming ticks
  urng_fifo #(
    .WIDTH (1),
    .DEPTH (2)
  ) u_tick_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (in_echo_level),
    .full  (full),
    .pop   (step),
    .rdata (tick_echo),
    .empty (tick_empty)
  );

  // Step the sequencer when a tick waits and the result queue has room
  assign step = !tick_empty && !res_full;

  // Back: phase sequencer
  urng_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .echo  (tick_echo),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Hold finished results until taken
  urng_fifo #(
    .WIDTH (RW),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (step),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_q_bits),
    .empty (empty)
  );

  assign res_q               = res_t'(res_q_bits);
  assign out_trigger_out     = res_q.trigger_out;
  assign out_alarm_on        = res_q.alarm_on;
  assign out_distance_cm     = res_q.distance_cm;
  assign out_distance_update = res_q.distance_update;
  assign out_out_of_range    = res_q.out_of_range;

  // A stepped tick always lands a result in the output queue
  a_step_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> !empty)
    else $error("stepped tick produced no result");

  // Trigger and alarm phases never overlap
  a_trig_alarm_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_trigger_out && out_alarm_on))
    else $error("trigger and alarm both driven");

  // Reset leaves both queues empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule

>>> rtl/urng_fifo.sv
// ----------------------------------------------------------------------------
// urng_fifo: small synchronous queue
// Register-based FIFO used to decouple the tick stream from the sequencer
// and to hold finished results until they are taken.
// ----------------------------------------------------------------------------
module urng_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entry data
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/urng_core.sv
// ----------------------------------------------------------------------------
// urng_core: ranging sequencer
// Steps the trigger / echo / guard / beep / gap phase machine by one clock
// tick per step and forms the result record for that tick. Distance is
// accumulated in centimeters while the echo is counted, so no divider.
// ----------------------------------------------------------------------------
module urng_core
  import urng_pkg::*;
#(
  parameter int COUNT_BITS = 20
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic echo,
  input  cfg_t cfg,
  output res_t res
);

  localparam int WW = (COUNT_BITS > US_W) ? COUNT_BITS : US_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  phase_t                phase_r, phase_nxt;
  logic [TPU_W-1:0]      pre_r, pre_nxt;
  logic [COUNT_BITS-1:0] mc_r, mc_nxt;
  logic [1:0]            gaps_r, gaps_nxt;
  logic [CM_W-1:0]       dist_r, dist_nxt;
  logic                  range_r, range_nxt;
  logic [DACC_W-1:0]     dacc_r, dacc_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;

  logic [TPU_W-1:0]      tpu_eff;
  logic                  fire;
  logic [COUNT_BITS-1:0] tgt;
  logic [COUNT_BITS:0]   mc_inc;
  logic                  t_done;
  logic [REM_W-1:0]      rem_sum;
  logic                  upd;

  // Clamp a microsecond setting to the counter range
  function automatic logic [COUNT_BITS-1:0] clamp_us(input logic [US_W-1:0] d);
    logic [WW-1:0] dw;
    logic [WW-1:0] mw;
    dw = WW'(d);
    mw = WW'(COUNT_MAX);
    return (dw > mw) ? COUNT_MAX : COUNT_BITS'(d);
  endfunction

  // Prescaler and timed-phase terminal count
  always_comb begin
    tpu_eff = (cfg.ticks_per_us == '0) ? TPU_W'(1) : cfg.ticks_per_us;
    fire    = ({1'b0, pre_r} + 9'd1) >= {1'b0, tpu_eff};
    unique case (phase_r)
      PH_LOW:   tgt = COUNT_BITS'(PRE_LOW_US);
      PH_TRIG:  tgt = COUNT_BITS'(TRIG_HIGH_US);
      PH_GUARD: tgt = clamp_us(cfg.guard_us);
      PH_BEEP:  tgt = clamp_us(cfg.beep_us);
      PH_GAP:   tgt = clamp_us(cfg.gap_us);
      default:  tgt = '0;
    endcase
    mc_inc  = {1'b0, mc_r} + 1'b1;
    t_done  = (tgt == '0) || (fire && (mc_inc >= {1'b0, tgt}));
    rem_sum = rem_r + REM_W'(DIST_MUL);
  end

  // Next state for one tick
  always_comb begin
    phase_nxt = phase_r;
    pre_nxt   = pre_r;
    mc_nxt    = mc_r;
    gaps_nxt  = gaps_r;
    dist_nxt  = dist_r;
    range_nxt = range_r;
    dacc_nxt  = dacc_r;
    rem_nxt   = rem_r;
    upd       = 1'b0;
    unique case (phase_r)
      PH_LOW, PH_TRIG, PH_GUARD, PH_BEEP, PH_GAP: begin
        if (t_done) begin
          pre_nxt = '0;
          mc_nxt  = '0;
        end else if (fire) begin
          pre_nxt = '0;
          mc_nxt  = mc_inc[COUNT_BITS-1:0];
        end else begin
          pre_nxt = TPU_W'(pre_r + 1'b1);
        end
        if (t_done) begin
          priority if (phase_r == PH_LOW) begin
            phase_nxt = PH_TRIG;
          end else if (phase_r == PH_TRIG) begin
            phase_nxt = PH_WAIT;
          end else if (phase_r == PH_GUARD) begin
            phase_nxt = PH_BEEP;
          end else if (phase_r == PH_BEEP) begin
            phase_nxt = (gaps_r != 2'd0) ? PH_GAP : PH_LOW;
          end else begin
            gaps_nxt = 2'(gaps_r - 1'b1);
            if (gaps_r == 2'd1) begin
              phase_nxt = PH_LOW;
            end
          end
        end
      end
      PH_WAIT: begin
        // Echo rise: start counting on the next tick
        if (echo) begin
          pre_nxt   = '0;
          mc_nxt    = '0;
          dacc_nxt  = '0;
          rem_nxt   = '0;
          phase_nxt = PH_MEAS;
        end
      end
      PH_MEAS: begin
        if (echo) begin
          if (fire) begin
            pre_nxt = '0;
            if (mc_r != COUNT_MAX) begin
              mc_nxt = mc_inc[COUNT_BITS-1:0];
              // Carry 17/1000 cm per microsecond into the distance count
              if (rem_sum >= REM_W'(DIST_DIV)) begin
                rem_nxt = REM_W'(rem_sum - REM_W'(DIST_DIV));
                if (dacc_r != DACC_W'(DIST_SAT)) begin
                  dacc_nxt = DACC_W'(dacc_r + 1'b1);
                end
              end else begin
                rem_nxt = rem_sum;
              end
            end
          end else begin
            pre_nxt = TPU_W'(pre_r + 1'b1);
          end
        end else begin
          // Echo fell: store the reading and, if in range, pick the alarm pattern
          upd     = 1'b1;
          pre_nxt = '0;
          mc_nxt  = '0;
          if (dacc_r >= {1'b0, cfg.max_range_cm}) begin
            dist_nxt  = cfg.max_range_cm;
            range_nxt = 1'b1;
            phase_nxt = PH_LOW;
          end else begin
            dist_nxt  = dacc_r[CM_W-1:0];
            range_nxt = 1'b0;
            priority if (dacc_r >= {1'b0, cfg.far_cm}) begin
              gaps_nxt = 2'd3;
            end else if (dacc_r >= {1'b0, cfg.mid_cm}) begin
              gaps_nxt = 2'd2;
            end else if (dacc_r >= {1'b0, cfg.near_cm}) begin
              gaps_nxt = 2'd1;
            end else begin
              gaps_nxt = 2'd0;
            end
            phase_nxt = PH_GUARD;
          end
        end
      end
      default: begin
        pre_nxt   = '0;
        mc_nxt    = '0;
        phase_nxt = PH_LOW;
      end
    endcase
  end

  // Result for this tick
  always_comb begin
    res.trigger_out     = (phase_r == PH_TRIG);
    res.alarm_on        = (phase_r == PH_BEEP);
    res.distance_cm     = dist_nxt;
    res.distance_update = upd;
    res.out_of_range    = range_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LOW;
      pre_r   <= '0;
      mc_r    <= '0;
      gaps_r  <= '0;
      dist_r  <= '0;
      range_r <= 1'b0;
      dacc_r  <= '0;
      rem_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pre_r   <= pre_nxt;
      mc_r    <= mc_nxt;
      gaps_r  <= gaps_nxt;
      dist_r  <= dist_nxt;
      range_r <= range_nxt;
      dacc_r  <= dacc_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule
